### hw/rtl/tt800_random_word_generator_defines.svh
// assertion macros for the tt800 random word generator
`ifndef TT800_RANDOM_WORD_GENERATOR_DEFINES_SVH
`define TT800_RANDOM_WORD_GENERATOR_DEFINES_SVH

// checked on every rising edge outside reset
`define TT800_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked in the cycle after the condition, outside reset
`define TT800_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`endif

### hw/rtl/tt800_pkg.sv
// shared types and constants of the tt800 random word generator
package tt800_pkg;

    localparam int RING_WORDS = 25;
    localparam int TAP_OFFSET = 7;
    localparam int WORD_W     = 32;
    localparam int POS_W      = 5;

    localparam logic [WORD_W-1:0] TWIST_VECTOR = 32'h8ebf_d028;
    localparam logic [WORD_W-1:0] TEMPER_B     = 32'h2b5b_2500;
    localparam logic [WORD_W-1:0] TEMPER_C     = 32'hdb8b_0000;

    // request kinds carried on tuser
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_DRAW  = 1'b1;

    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [WORD_W-1:0] word_t;

    // one write into the ring memory
    typedef struct packed {
        logic  en;
        pos_t  addr;
        word_t data;
    } wr_req_t;

    // two reads from the ring memory
    typedef struct packed {
        logic en;
        pos_t addr_cur;
        pos_t addr_tap;
    } rd_req_t;

endpackage

### hw/rtl/tt800_ring_mem.sv
// ring memory: one write port, two registered read ports
module tt800_ring_mem
(
    input  logic                clk,
    input  tt800_pkg::wr_req_t  wr,
    input  tt800_pkg::rd_req_t  rd,
    output tt800_pkg::word_t    rd_cur,
    output tt800_pkg::word_t    rd_tap
);

    tt800_pkg::word_t mem [tt800_pkg::RING_WORDS];
    tt800_pkg::word_t rd_cur_reg;
    tt800_pkg::word_t rd_tap_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_cur_reg <= mem[rd.addr_cur];
            rd_tap_reg <= mem[rd.addr_tap];
        end
    end

    assign rd_cur = rd_cur_reg;
    assign rd_tap = rd_tap_reg;

endmodule

### hw/rtl/tt800_twist_temper.sv
// twist of one ring word and tempering of the drawn word
module tt800_twist_temper
(
    input  tt800_pkg::word_t cur,
    input  tt800_pkg::word_t tap,
    input  logic             twist_en,
    output tt800_pkg::word_t twisted,
    output tt800_pkg::word_t tempered
);

    tt800_pkg::word_t mixed;
    tt800_pkg::word_t word;
    tt800_pkg::word_t y1;
    tt800_pkg::word_t y2;

    always_comb
    begin
        mixed = tap ^ (cur >> 1) ^ (cur[0] ? tt800_pkg::TWIST_VECTOR : '0);
        word  = twist_en ? mixed : cur;
        y1    = word ^ ((word << 7) & tt800_pkg::TEMPER_B);
        y2    = y1 ^ ((y1 << 15) & tt800_pkg::TEMPER_C);
    end

    assign twisted  = mixed;
    assign tempered = y2 ^ (y2 >> 16);

endmodule

### hw/rtl/tt800_random_word_generator.sv
// top level of the tt800 random word generator
// tt800 twisted gfsr generator. the 25-word state ring sits in a synchronous
// memory with two read ports and one write port. a write request (tuser = 0)
// loads one ring word and restarts the stream at slot 0 on an untwisted pass;
// a write to a slot above 24 is taken and ignored. a draw request (tuser = 1)
// returns one tempered word. on the first pass after loading the words are
// drawn untwisted; on later passes each slot is twisted with the word seven
// places ahead just before it is drawn, and the new word is written back.
// draws are taken one per clock cycle while the output is not stalled; each
// result passes from the memory read registers through twist and temper into
// the output register. the memory's single write port adds a wait of its own:
// a write request that arrives in the cycle a twisted word is being written
// back is held. the ring must be fully loaded before the first draw.
module tt800_random_word_generator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // word_index[4:0], word_value[36:5], zero pad
    input  logic        s_axis_tuser,  // action[0]: 0 write, 1 draw
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // random_word[31:0]
);

    localparam tt800_pkg::pos_t LAST_POS  = tt800_pkg::POS_W'(tt800_pkg::RING_WORDS - 1);
    localparam tt800_pkg::pos_t TAP_WRAP  =
        tt800_pkg::POS_W'(tt800_pkg::RING_WORDS - tt800_pkg::TAP_OFFSET);
    localparam tt800_pkg::pos_t TAP_STEP  = tt800_pkg::POS_W'(tt800_pkg::TAP_OFFSET);
    localparam tt800_pkg::pos_t NUM_SLOTS = tt800_pkg::POS_W'(tt800_pkg::RING_WORDS);

    // request fields
    tt800_pkg::pos_t  word_index;
    tt800_pkg::word_t word_value;

    assign word_index = s_axis_tdata[4:0];
    assign word_value = s_axis_tdata[36:5];

    // stream position and pass flag
    tt800_pkg::pos_t pos_reg, pos_next;
    logic            twisted_reg, twisted_next;

    // stage 1: memory data in flight
    logic            s1_valid_reg, s1_valid_next;
    tt800_pkg::pos_t s1_pos_reg, s1_pos_next;
    logic            s1_twist_reg, s1_twist_next;
    logic            s1_wb_reg, s1_wb_next;    // twisted word not yet written back

    // output register
    logic             out_valid_reg, out_valid_next;
    tt800_pkg::word_t out_data_reg, out_data_next;

    logic               accept;
    logic               draw_acc;
    logic               host_wr;
    logic               wb_en;
    logic               s1_adv;
    logic               s1_free;
    tt800_pkg::pos_t    tap_pos;
    tt800_pkg::wr_req_t wr;
    tt800_pkg::rd_req_t rd;
    tt800_pkg::word_t   rd_cur;
    tt800_pkg::word_t   rd_tap;
    tt800_pkg::word_t   twisted;
    tt800_pkg::word_t   tempered;

    tt800_ring_mem u_mem
    (
        .clk    (clk),
        .wr     (wr),
        .rd     (rd),
        .rd_cur (rd_cur),
        .rd_tap (rd_tap)
    );

    tt800_twist_temper u_tt
    (
        .cur      (rd_cur),
        .tap      (rd_tap),
        .twist_en (s1_twist_reg),
        .twisted  (twisted),
        .tempered (tempered)
    );

    // handshake and hazards
    always_comb
    begin
        s1_adv  = s1_valid_reg && (!out_valid_reg || m_axis_tready);
        s1_free = !s1_valid_reg || s1_adv;
        wb_en   = s1_valid_reg && s1_wb_reg;
        // draws need room in stage 1; writes need the memory write port
        s_axis_tready = (s_axis_tuser == tt800_pkg::ACT_DRAW) ? s1_free : !wb_en;
        accept   = s_axis_tvalid && s_axis_tready;
        draw_acc = accept && (s_axis_tuser == tt800_pkg::ACT_DRAW);
        host_wr  = accept && (s_axis_tuser == tt800_pkg::ACT_WRITE) && (word_index < NUM_SLOTS);
        tap_pos  = (pos_reg >= TAP_WRAP) ? pos_reg - TAP_WRAP : pos_reg + TAP_STEP;
    end

    // memory requests: a write-back never meets a host write (interlock above)
    always_comb
    begin
        rd.en       = draw_acc;
        rd.addr_cur = pos_reg;
        rd.addr_tap = tap_pos;
        wr.en       = host_wr || wb_en;
        wr.addr     = wb_en ? s1_pos_reg : word_index;
        wr.data     = wb_en ? twisted : word_value;
    end

    // next state
    always_comb
    begin
        pos_next       = pos_reg;
        twisted_next   = twisted_reg;
        s1_valid_next  = s1_valid_reg;
        s1_pos_next    = s1_pos_reg;
        s1_twist_next  = s1_twist_reg;
        s1_wb_next     = s1_wb_reg && !wb_en;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (host_wr)
        begin
            pos_next     = '0;
            twisted_next = 1'b0;
        end
        else if (draw_acc)
        begin
            if (pos_reg == LAST_POS)
            begin
                pos_next     = '0;
                twisted_next = 1'b1;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
        end

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
            out_data_next  = tempered;
            s1_valid_next  = 1'b0;
        end

        if (draw_acc)
        begin
            s1_valid_next = 1'b1;
            s1_pos_next   = pos_reg;
            s1_twist_next = twisted_reg;
            s1_wb_next    = twisted_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            twisted_reg   <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s1_wb_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            twisted_reg   <= twisted_next;
            s1_valid_reg  <= s1_valid_next;
            s1_wb_reg     <= s1_wb_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_pos_reg   <= s1_pos_next;
        s1_twist_reg <= s1_twist_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `include "tt800_random_word_generator_defines.svh"

    // the read position never leaves the ring
    `TT800_ASSERT(a_pos_in_ring, pos_reg <= LAST_POS, "read position outside ring")
    // the memory write port is never claimed twice
    `TT800_ASSERT(a_one_writer, !(host_wr && wb_en), "write-back collides with host write")
    // every accepted draw lands in stage 1
    `TT800_ASSERT_NEXT(a_draw_in_s1, draw_acc, s1_valid_reg, "accepted draw lost")

endmodule
